// ===== rtl/core/hds_pkg.sv =====
// hds_pkg: shared types and constants of the heat diffusion stencil block
// no dependencies; used by every module under rtl/core

package hds_pkg;

   localparam int TEMP_W    = 24;
   localparam int COORD_W   = 7;
   localparam int OP_W      = 2;
   localparam int ITER_W    = 16;
   localparam int SIDE_W    = 7;
   localparam int LIM_W     = 8;
   localparam int KIND_W    = 2;

   // five-term sum and the reciprocal of five; quotient is exact for every 27-bit sum
   localparam int SUM_W     = 27;
   localparam int RECIP_W   = 28;
   localparam int PROD_W    = SUM_W + RECIP_W;
   localparam int DIV_SHIFT = 30;
   localparam logic [RECIP_W-1:0] RECIP = 28'd214748365;

   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_RUN   = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   localparam logic [KIND_W-1:0] RSP_WRITE = 2'd0;
   localparam logic [KIND_W-1:0] RSP_RUN   = 2'd1;
   localparam logic [KIND_W-1:0] RSP_READ  = 2'd2;

   localparam logic [ITER_W-1:0] ITER_RESET = 16'd1000;
   localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd64;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [TEMP_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] reply_kind;
      logic [TEMP_W-1:0] data;
   } rsp_type;

   typedef struct packed {
      logic add;
      logic first;
      logic mul;
      logic border;
   } alu_ctl_type;

   typedef struct packed {
      logic we_a;
      logic we_b;
      logic cur;
   } bank_ctl_type;

   typedef struct packed {
      logic              valid;
      logic [KIND_W-1:0] kind;
      logic              ok;
   } resp_ctl_type;

endpackage

// ===== rtl/core/heat_diffusion_stencil.sv =====
// heat_diffusion_stencil: top level, register port, two grid banks and result stage
// depends on hds_pkg, hds_bank, hds_alu and hds_seq
//
//   channel   ports                               handshake
//   request   start, busy, req_payload            beat taken when start && !busy
//   result    rsp_valid, rsp_payload              one-cycle strobe, no back pressure
//   config    psel penable pwrite paddr pwdata    write on psel&penable&pwrite&pready
//             prdata pready                       pready tied high
//
// write and read items stream one per cycle when idle. a run takes iteration_count sweeps
// over (n+2)^2 cells, n the clipped interior side, then one copy pass over the same cells
// so both banks hold the final grid: each border or copied cell takes one read, each
// interior cell five reads, then every cell a drain, multiply and write, set by the single
// read port of the grid bank feeding one accumulator. each result strobe, the run-finished
// one too, is registered in hds_seq and in the result stage; busy is high for the whole run.
// synchronous reset clears control only; the grid holds nothing defined until written.

module heat_diffusion_stencil #(
   parameter int SIDE = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  hds_pkg::req_type           req_payload,
   output logic                       rsp_valid,
   output hds_pkg::rsp_type           rsp_payload,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [2:0]                 paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   localparam int DIM    = SIDE + 2;
   localparam int CELLS  = DIM * DIM;
   localparam int ADDR_W = $clog2(CELLS);

   logic [hds_pkg::ITER_W-1:0] csr_iter_ff;
   logic [hds_pkg::SIDE_W-1:0] csr_side_ff;
   logic                       csr_wr;

   logic [ADDR_W-1:0]          rd_addr, wr_addr;
   logic [hds_pkg::TEMP_W-1:0] wr_data;
   logic [hds_pkg::TEMP_W-1:0] rdata_a, rdata_b, rd_data;
   logic [hds_pkg::TEMP_W-1:0] alu_result;
   hds_pkg::bank_ctl_type      bank_ctl;
   hds_pkg::alu_ctl_type       alu_ctl;
   hds_pkg::resp_ctl_type      resp_ctl;

   logic                       rsp_valid_ff;
   hds_pkg::rsp_type           rsp_payload_ff;

   // register port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;
   assign prdata = paddr[2] ? 32'(csr_side_ff) : 32'(csr_iter_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_iter_ff <= hds_pkg::ITER_RESET;
         csr_side_ff <= hds_pkg::SIDE_RESET;
      end else if (csr_wr) begin
         if (paddr[2]) begin
            csr_side_ff <= pwdata[hds_pkg::SIDE_W-1:0];
         end else begin
            csr_iter_ff <= pwdata[hds_pkg::ITER_W-1:0];
         end
      end
   end

   hds_seq #(
      .SIDE(SIDE)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req        (req_payload),
      .side_cfg   (csr_side_ff),
      .iter_cfg   (csr_iter_ff),
      .alu_result (alu_result),
      .busy       (busy),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .bank_ctl   (bank_ctl),
      .alu_ctl    (alu_ctl),
      .resp_ctl   (resp_ctl)
   );

   hds_bank #(
      .DEPTH (CELLS),
      .ADDR_W(ADDR_W)
   ) u_bank_a (
      .clock (clock),
      .we    (bank_ctl.we_a),
      .waddr (wr_addr),
      .wdata (wr_data),
      .raddr (rd_addr),
      .rdata (rdata_a)
   );

   hds_bank #(
      .DEPTH (CELLS),
      .ADDR_W(ADDR_W)
   ) u_bank_b (
      .clock (clock),
      .we    (bank_ctl.we_b),
      .waddr (wr_addr),
      .wdata (wr_data),
      .raddr (rd_addr),
      .rdata (rdata_b)
   );

   // the bank holding the present grid
   assign rd_data = bank_ctl.cur ? rdata_b : rdata_a;

   hds_alu u_alu (
      .clock   (clock),
      .ctl     (alu_ctl),
      .rd_data (rd_data),
      .result  (alu_result)
   );

   // result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= resp_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff.reply_kind <= resp_ctl.kind;
      if ((resp_ctl.kind == hds_pkg::RSP_READ) && resp_ctl.ok) begin
         rsp_payload_ff.data <= rd_data;
      end else begin
         rsp_payload_ff.data <= '0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // a sweep writes only the bank that is not being read
   assert property (@(posedge clock) disable iff (reset)
      busy |-> !(bank_ctl.we_a && bank_ctl.we_b))
      else $error("sweep wrote both banks");

   // only read beats carry data
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.reply_kind != hds_pkg::RSP_READ)) |-> (rsp_payload.data == '0))
      else $error("nonzero data on a non-read result");

   // a run with sweeps to do holds the block busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_payload.operation == hds_pkg::OP_RUN) && (csr_iter_ff != '0))
      |=> busy)
      else $error("run did not start");

   // no result is produced while a run is in progress
   assert property (@(posedge clock) disable iff (reset)
      ($past(busy) && busy) |-> !resp_ctl.valid)
      else $error("result raised during a run");

endmodule

// ===== rtl/core/hds_bank.sv =====
// hds_bank: one grid bank, single write port, single registered read port
// depends on hds_pkg for the temperature width

module hds_bank #(
   parameter int DEPTH  = 4356,
   parameter int ADDR_W = 13
) (
   input  logic                      clock,
   input  logic                      we,
   input  logic [ADDR_W-1:0]         waddr,
   input  logic [hds_pkg::TEMP_W-1:0] wdata,
   input  logic [ADDR_W-1:0]         raddr,
   output logic [hds_pkg::TEMP_W-1:0] rdata
);

   logic [hds_pkg::TEMP_W-1:0] mem [DEPTH];
   logic [hds_pkg::TEMP_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/hds_alu.sv =====
// hds_alu: shared accumulator and reciprocal divide-by-five unit
// depends on hds_pkg for widths, the reciprocal and the control struct

module hds_alu (
   input  logic                       clock,
   input  hds_pkg::alu_ctl_type       ctl,
   input  logic [hds_pkg::TEMP_W-1:0] rd_data,
   output logic [hds_pkg::TEMP_W-1:0] result
);

   logic [hds_pkg::SUM_W-1:0]  acc_ff;
   logic [hds_pkg::SUM_W-1:0]  acc_in;
   logic [hds_pkg::PROD_W-1:0] prod_ff;

   always_comb begin
      if (ctl.first) begin
         acc_in = hds_pkg::SUM_W'(rd_data);
      end else begin
         acc_in = acc_ff + hds_pkg::SUM_W'(rd_data);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.add) begin
         acc_ff <= acc_in;
      end
      if (ctl.mul) begin
         prod_ff <= hds_pkg::PROD_W'(acc_ff) * hds_pkg::PROD_W'(hds_pkg::RECIP);
      end
   end

   // border cells only carry their own value through
   assign result = ctl.border ? acc_ff[hds_pkg::TEMP_W-1:0]
                              : prod_ff[hds_pkg::DIV_SHIFT +: hds_pkg::TEMP_W];

endmodule

// ===== rtl/core/hds_seq.sv =====
// hds_seq: item decode, sweep sequencer, cell counters and bank addressing
// depends on hds_pkg for the request type, codes and control structs

module hds_seq #(
   parameter  int SIDE   = 64,
   localparam int DIM    = SIDE + 2,
   localparam int CELLS  = DIM * DIM,
   localparam int ADDR_W = $clog2(CELLS)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  hds_pkg::req_type            req,
   input  logic [hds_pkg::SIDE_W-1:0]  side_cfg,
   input  logic [hds_pkg::ITER_W-1:0]  iter_cfg,
   input  logic [hds_pkg::TEMP_W-1:0]  alu_result,
   output logic                        busy,
   output logic [ADDR_W-1:0]           rd_addr,
   output logic [ADDR_W-1:0]           wr_addr,
   output logic [hds_pkg::TEMP_W-1:0]  wr_data,
   output hds_pkg::bank_ctl_type       bank_ctl,
   output hds_pkg::alu_ctl_type        alu_ctl,
   output hds_pkg::resp_ctl_type       resp_ctl
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_READ  = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_MUL   = 5'b01000,
      ST_WRITE = 5'b10000
   } seq_state_type;

   localparam int CLIP = (SIDE < 127) ? SIDE : 127;
   localparam logic [hds_pkg::SIDE_W-1:0] CLIP_S = hds_pkg::SIDE_W'(CLIP);
   localparam logic [ADDR_W-1:0] DIM_A = ADDR_W'(DIM);
   localparam logic [ADDR_W-1:0] ONE_A = ADDR_W'(1);

   localparam logic [2:0] TAP_SELF  = 3'd0;
   localparam logic [2:0] TAP_NORTH = 3'd1;
   localparam logic [2:0] TAP_SOUTH = 3'd2;
   localparam logic [2:0] TAP_WEST  = 3'd3;
   localparam logic [2:0] TAP_LAST  = 3'd4;

   seq_state_type               state_ff, state_in;
   logic [hds_pkg::LIM_W-1:0]   row_ff, row_in;
   logic [hds_pkg::LIM_W-1:0]   col_ff, col_in;
   logic [2:0]                  tap_ff, tap_in;
   logic [hds_pkg::ITER_W-1:0]  sweep_ff, sweep_in;
   logic                        cur_ff, cur_in;
   logic                        copy_ff, copy_in;
   logic                        add_ff, add_in;
   logic                        first_ff, first_in;
   hds_pkg::resp_ctl_type       resp_ff, resp_in;

   logic [hds_pkg::SIDE_W-1:0]  side_n;
   logic [hds_pkg::LIM_W-1:0]   lim;
   logic                        idle;
   logic                        accept;
   logic [hds_pkg::LIM_W-1:0]   arow, acol;
   logic [ADDR_W-1:0]           cell_addr, tap_addr;
   logic                        req_ok;
   logic                        border;
   logic                        last_tap;
   logic [hds_pkg::ITER_W-1:0]  sweep_next;

   assign side_n = (side_cfg > CLIP_S) ? CLIP_S : side_cfg;
   assign lim    = hds_pkg::LIM_W'(side_n) + hds_pkg::LIM_W'(1);
   assign idle   = (state_ff == ST_IDLE);
   assign accept = start && idle;
   assign busy   = !idle;

   assign arow = idle ? hds_pkg::LIM_W'(req.row) : row_ff;
   assign acol = idle ? hds_pkg::LIM_W'(req.col) : col_ff;
   assign cell_addr = ADDR_W'(int'(arow) * DIM + int'(acol));

   assign req_ok = (hds_pkg::LIM_W'(req.row) <= lim) && (hds_pkg::LIM_W'(req.col) <= lim);
   // the closing copy pass carries every cell through like a border cell
   assign border = copy_ff || (row_ff == '0) || (col_ff == '0) || (row_ff == lim)
                   || (col_ff == lim);
   assign last_tap   = border ? (tap_ff == TAP_SELF) : (tap_ff == TAP_LAST);
   assign sweep_next = sweep_ff + hds_pkg::ITER_W'(1);

   always_comb begin
      case (tap_ff)
         TAP_SELF:  tap_addr = cell_addr;
         TAP_NORTH: tap_addr = cell_addr - DIM_A;
         TAP_SOUTH: tap_addr = cell_addr + DIM_A;
         TAP_WEST:  tap_addr = cell_addr - ONE_A;
         default:   tap_addr = cell_addr + ONE_A;
      endcase
   end

   assign rd_addr = idle ? cell_addr : tap_addr;
   assign wr_addr = cell_addr;
   assign wr_data = idle ? req.value : alu_result;

   // item writes go to both banks so border cells agree in both
   assign bank_ctl.we_a = idle ? (accept && (req.operation == hds_pkg::OP_WRITE) && req_ok)
                               : ((state_ff == ST_WRITE) && cur_ff);
   assign bank_ctl.we_b = idle ? (accept && (req.operation == hds_pkg::OP_WRITE) && req_ok)
                               : ((state_ff == ST_WRITE) && !cur_ff);
   assign bank_ctl.cur  = cur_ff;

   assign alu_ctl.add    = add_ff;
   assign alu_ctl.first  = first_ff;
   assign alu_ctl.mul    = (state_ff == ST_MUL);
   assign alu_ctl.border = border;

   assign resp_ctl = resp_ff;

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      tap_in   = tap_ff;
      sweep_in = sweep_ff;
      cur_in   = cur_ff;
      copy_in  = copy_ff;
      add_in   = (state_ff == ST_READ);
      first_in = (tap_ff == TAP_SELF);
      resp_in  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req.operation)
                  hds_pkg::OP_WRITE: begin
                     resp_in = '{valid: 1'b1, kind: hds_pkg::RSP_WRITE, ok: req_ok};
                  end
                  hds_pkg::OP_READ: begin
                     resp_in = '{valid: 1'b1, kind: hds_pkg::RSP_READ, ok: req_ok};
                  end
                  hds_pkg::OP_RUN: begin
                     if (iter_cfg == '0) begin
                        resp_in = '{valid: 1'b1, kind: hds_pkg::RSP_RUN, ok: 1'b0};
                     end else begin
                        state_in = ST_READ;
                        row_in   = '0;
                        col_in   = '0;
                        tap_in   = TAP_SELF;
                        sweep_in = '0;
                        copy_in  = 1'b0;
                     end
                  end
                  default: begin
                     resp_in = '0;
                  end
               endcase
            end
         end
         ST_READ: begin
            if (last_tap) begin
               tap_in   = TAP_SELF;
               state_in = ST_DRAIN;
            end else begin
               tap_in = tap_ff + 3'd1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            state_in = ST_READ;
            if (col_ff == lim) begin
               col_in = '0;
               if (row_ff == lim) begin
                  row_in = '0;
                  if (copy_ff) begin
                     state_in = ST_IDLE;
                     copy_in  = 1'b0;
                     resp_in  = '{valid: 1'b1, kind: hds_pkg::RSP_RUN, ok: 1'b0};
                  end else begin
                     cur_in = !cur_ff;
                     if (sweep_next == iter_cfg) begin
                        // both banks must hold the final grid before the next run
                        copy_in  = 1'b1;
                        sweep_in = '0;
                     end else begin
                        sweep_in = sweep_next;
                     end
                  end
               end else begin
                  row_in = row_ff + hds_pkg::LIM_W'(1);
               end
            end else begin
               col_in = col_ff + hds_pkg::LIM_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         tap_ff   <= TAP_SELF;
         sweep_ff <= '0;
         cur_ff   <= 1'b0;
         copy_ff  <= 1'b0;
         add_ff   <= 1'b0;
         first_ff <= 1'b0;
         resp_ff  <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         tap_ff   <= tap_in;
         sweep_ff <= sweep_in;
         cur_ff   <= cur_in;
         copy_ff  <= copy_in;
         add_ff   <= add_in;
         first_ff <= first_in;
         resp_ff  <= resp_in;
      end
   end

endmodule

// ===== dv/diffusion_tracker_pkg.sv =====
`timescale 1ns / 100ps
// diffusion_tracker_pkg: grid shadow and reply scoreboard for the heat diffusion stencil bench
// depends on hds_pkg for the request and reply types and the operation codes

package diffusion_tracker_pkg;

   localparam int GRID_SIDE  = 64;
   localparam int GRID_DIM   = GRID_SIDE + 2;
   localparam int CELL_COUNT = GRID_DIM * GRID_DIM;
   localparam int unsigned DIFFUSION_DIVISOR = 5;

   class diffusion_tracker;
      logic [hds_pkg::TEMP_W-1:0] grid [CELL_COUNT];
      logic [hds_pkg::TEMP_W-1:0] scratch [CELL_COUNT];
      bit                         written [CELL_COUNT];
      logic [hds_pkg::ITER_W-1:0] sweeps;
      logic [hds_pkg::SIDE_W-1:0] side_reg;
      hds_pkg::rsp_type           pending_replies [$];
      int                         error_count;

      function new();
         sweeps      = hds_pkg::ITER_RESET;
         side_reg    = hds_pkg::SIDE_RESET;
         error_count = 0;
         foreach (grid[i]) begin
            grid[i]    = '0;
            scratch[i] = '0;
            written[i] = 1'b0;
         end
      endfunction

      function int active_side();
         return (side_reg > GRID_SIDE) ? GRID_SIDE : int'(side_reg);
      endfunction

      function bit in_grid(int r, int c);
         return (r <= active_side() + 1) && (c <= active_side() + 1);
      endfunction

      // jacobi sweeps over the interior; border cells stay put
      function void diffuse();
         int n;
         int p;
         int unsigned heat_sum;
         n = active_side();
         for (int k = 0; k < int'(sweeps); k++) begin
            for (int r = 1; r <= n; r++) begin
               for (int c = 1; c <= n; c++) begin
                  p = r * GRID_DIM + c;
                  heat_sum = int'(grid[p]) + int'(grid[p - GRID_DIM]) + int'(grid[p + GRID_DIM])
                           + int'(grid[p - 1]) + int'(grid[p + 1]);
                  scratch[p] = hds_pkg::TEMP_W'(heat_sum / DIFFUSION_DIVISOR);
               end
            end
            for (int r = 1; r <= n; r++) begin
               for (int c = 1; c <= n; c++) begin
                  grid[r * GRID_DIM + c] = scratch[r * GRID_DIM + c];
               end
            end
         end
      endfunction

      function void note_request(hds_pkg::req_type item);
         hds_pkg::rsp_type reply;
         int p;
         reply.reply_kind = hds_pkg::RSP_WRITE;
         reply.data       = '0;
         p = 0;
         if (in_grid(item.row, item.col))
            p = int'(item.row) * GRID_DIM + int'(item.col);
         case (item.operation)
            hds_pkg::OP_WRITE: begin
               if (in_grid(item.row, item.col)) begin
                  grid[p]    = item.value;
                  written[p] = 1'b1;
               end
               pending_replies.push_back(reply);
            end
            hds_pkg::OP_RUN: begin
               diffuse();
               reply.reply_kind = hds_pkg::RSP_RUN;
               pending_replies.push_back(reply);
            end
            hds_pkg::OP_READ: begin
               reply.reply_kind = hds_pkg::RSP_READ;
               if (in_grid(item.row, item.col))
                  reply.data = grid[p];
               pending_replies.push_back(reply);
            end
            default: ;
         endcase
      endfunction

      function void check_reply(hds_pkg::rsp_type got);
         hds_pkg::rsp_type want;
         if (pending_replies.size() == 0) begin
            $error("reply with nothing pending: reply_kind %0d, data %0h",
                   got.reply_kind, got.data);
            error_count++;
            return;
         end
         want = pending_replies.pop_front();
         if (got.reply_kind !== want.reply_kind) begin
            $error("reply_kind mismatch: expected %0d, got %0d", want.reply_kind, got.reply_kind);
            error_count++;
         end
         if (got.data !== want.data) begin
            $error("data mismatch: expected %0h, got %0h", want.data, got.data);
            error_count++;
         end
      endfunction
   endclass

endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking bench for heat_diffusion_stencil, cell loads, sweeps and reads
// depends on hds_pkg, diffusion_tracker_pkg and the heat_diffusion_stencil rtl

module tb_top;

   localparam logic [hds_pkg::OP_W-1:0] OP_IGNORED = 2'd3;
   localparam logic [2:0]      ADDR_ITER  = 3'd0;
   localparam logic [2:0]      ADDR_SIDE  = 3'd4;
   localparam int unsigned     STALL_LIMIT  = 4_000_000;
   localparam int unsigned     RANDOM_ITEMS = 1250;
   localparam logic [hds_pkg::TEMP_W-1:0] TEMP_MAX = '1;

   logic              clock   = 1'b0;
   logic              reset   = 1'b1;
   logic              start   = 1'b0;
   logic              busy;
   hds_pkg::req_type  req_payload = '0;
   logic              rsp_valid;
   hds_pkg::rsp_type  rsp_payload;
   logic              psel    = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite  = 1'b0;
   logic [2:0]        paddr   = '0;
   logic [31:0]       pwdata  = '0;
   logic [31:0]       prdata;
   logic              pready;

   diffusion_tracker_pkg::diffusion_tracker tracker;
   int          gap_pct = 33;
   int unsigned counted_items = 0;
   int unsigned stall_cycles = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   heat_diffusion_stencil #(.SIDE(diffusion_tracker_pkg::GRID_SIDE)) uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         tracker.check_reply(rsp_payload);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic logic [hds_pkg::TEMP_W-1:0] random_temp();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return TEMP_MAX;
         default: return hds_pkg::TEMP_W'($urandom());
      endcase
   endfunction

   task automatic issue(input logic [hds_pkg::OP_W-1:0] op, input int r, input int c,
                        input logic [hds_pkg::TEMP_W-1:0] v);
      hds_pkg::req_type item;
      item.operation = op;
      item.row       = r[hds_pkg::COORD_W-1:0];
      item.col       = c[hds_pkg::COORD_W-1:0];
      item.value     = v;
      while ($urandom_range(0, 99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      tracker.note_request(item);
      if (op != OP_IGNORED)
         counted_items++;
   endtask

   // drain replies, then give an ignored beat time to clear the pipe
   task automatic settle();
      start <= 1'b0;
      while (tracker.pending_replies.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_access(input bit is_write, input logic [2:0] addr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= addr;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic verify_csrs();
      logic [31:0] rd;
      csr_access(1'b0, ADDR_ITER, '0, rd);
      if (rd[hds_pkg::ITER_W-1:0] !== tracker.sweeps) begin
         $error("iteration_count mismatch: expected %0d, got %0d", tracker.sweeps,
                rd[hds_pkg::ITER_W-1:0]);
         tracker.error_count++;
      end
      csr_access(1'b0, ADDR_SIDE, '0, rd);
      if (rd[hds_pkg::SIDE_W-1:0] !== tracker.side_reg) begin
         $error("interior_side mismatch: expected %0d, got %0d", tracker.side_reg,
                rd[hds_pkg::SIDE_W-1:0]);
         tracker.error_count++;
      end
   endtask

   task automatic configure(input int iters, input int side);
      logic [31:0] rd;
      settle();
      csr_access(1'b1, ADDR_ITER, iters, rd);
      tracker.sweeps = hds_pkg::ITER_W'(iters);
      csr_access(1'b1, ADDR_SIDE, side, rd);
      tracker.side_reg = hds_pkg::SIDE_W'(side);
      verify_csrs();
   endtask

   // every cell in use must hold a value before any run or read touches it
   task automatic fill_grid(input bit rewrite_all);
      int lim;
      lim = tracker.active_side() + 1;
      for (int r = 0; r <= lim; r++) begin
         for (int c = 0; c <= lim; c++) begin
            if (rewrite_all || !tracker.written[r * diffusion_tracker_pkg::GRID_DIM + c])
               issue(hds_pkg::OP_WRITE, r, c, random_temp());
         end
      end
   endtask

   task automatic random_round(input int n_ops);
      int lim;
      int pick;
      lim = tracker.active_side() + 1;
      repeat (n_ops) begin
         pick = $urandom_range(0, 99);
         if (pick < 45)
            issue(hds_pkg::OP_WRITE, $urandom_range(0, lim), $urandom_range(0, lim),
                  random_temp());
         else if (pick < 82)
            issue(hds_pkg::OP_READ, $urandom_range(0, lim), $urandom_range(0, lim),
                  hds_pkg::TEMP_W'($urandom()));
         else if (pick < 88)
            issue(hds_pkg::OP_RUN, $urandom_range(0, 127), $urandom_range(0, 127),
                  hds_pkg::TEMP_W'($urandom()));
         else
            issue(hds_pkg::OP_W'($urandom_range(0, 3)), $urandom_range(0, 127),
                  $urandom_range(0, 127), hds_pkg::TEMP_W'($urandom()));
      end
   endtask

   initial begin
      tracker = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      verify_csrs();

      // small grid, one sweep, checkerboard of extremes
      configure(1, 2);
      for (int r = 0; r <= 3; r++) begin
         for (int c = 0; c <= 3; c++) begin
            issue(hds_pkg::OP_WRITE, r, c, ((r + c) % 2) ? TEMP_MAX : '0);
         end
      end
      issue(hds_pkg::OP_WRITE, 2, 2, 24'h5a5a5a);
      issue(hds_pkg::OP_RUN, 0, 0, '0);
      issue(hds_pkg::OP_READ, 1, 1, '0);
      issue(hds_pkg::OP_READ, 2, 2, '0);
      issue(hds_pkg::OP_READ, 0, 0, '0);
      issue(hds_pkg::OP_READ, 3, 3, TEMP_MAX);
      // outside the grid in use: write dropped, read gives zero
      issue(hds_pkg::OP_WRITE, 4, 0, TEMP_MAX);
      issue(hds_pkg::OP_WRITE, 127, 127, TEMP_MAX);
      issue(hds_pkg::OP_READ, 127, 0, '0);
      issue(hds_pkg::OP_READ, 4, 4, '0);
      issue(OP_IGNORED, 1, 1, TEMP_MAX);
      issue(hds_pkg::OP_READ, 1, 1, '0);

      // zero sweeps leave the grid alone
      configure(0, 2);
      issue(hds_pkg::OP_RUN, 1, 1, '0);
      issue(hds_pkg::OP_READ, 2, 1, '0);

      // no interior at all
      configure(3, 0);
      issue(hds_pkg::OP_WRITE, 0, 0, TEMP_MAX);
      issue(hds_pkg::OP_WRITE, 0, 1, '0);
      issue(hds_pkg::OP_WRITE, 1, 0, TEMP_MAX);
      issue(hds_pkg::OP_WRITE, 1, 1, 24'h000001);
      issue(hds_pkg::OP_WRITE, 2, 2, TEMP_MAX);
      issue(hds_pkg::OP_RUN, 0, 0, '0);
      issue(hds_pkg::OP_READ, 1, 1, '0);
      issue(hds_pkg::OP_READ, 2, 0, '0);

      counted_items = 0;
      while (counted_items < RANDOM_ITEMS) begin
         if (counted_items < RANDOM_ITEMS / 3)
            gap_pct = 33;
         else if (counted_items < 2 * RANDOM_ITEMS / 3)
            gap_pct = 83;
         else
            gap_pct = 0;
         configure(($urandom_range(0, 9) == 0) ? $urandom_range(7, 30) : $urandom_range(0, 6),
                   $urandom_range(0, 6));
         fill_grid(1'b1);
         random_round($urandom_range(20, 60));
      end

      // side above the storage limit is held to the full grid
      gap_pct = 0;
      configure(1, 127);
      issue(hds_pkg::OP_WRITE, 65, 65, random_temp());
      issue(hds_pkg::OP_WRITE, 0, 65, TEMP_MAX);
      issue(hds_pkg::OP_WRITE, 66, 66, TEMP_MAX);
      issue(hds_pkg::OP_READ, 65, 65, '0);
      issue(hds_pkg::OP_READ, 0, 65, '0);
      issue(hds_pkg::OP_READ, 66, 66, '0);
      issue(hds_pkg::OP_READ, 65, 66, '0);
      configure(1, 64);
      issue(hds_pkg::OP_WRITE, 66, 0, TEMP_MAX);
      issue(hds_pkg::OP_READ, 65, 65, '0);
      issue(hds_pkg::OP_READ, 66, 0, '0);

      // longest sweep count on the empty interior
      configure(16'hffff, 0);
      fill_grid(1'b1);
      issue(hds_pkg::OP_RUN, 0, 0, '0);
      issue(hds_pkg::OP_READ, 0, 0, '0);
      issue(hds_pkg::OP_READ, 1, 1, '0);
      issue(hds_pkg::OP_READ, 0, 1, '0);
      settle();

      if (tracker.error_count == 0 && tracker.pending_replies.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/hds_pkg.sv
rtl/core/hds_bank.sv
rtl/core/hds_alu.sv
rtl/core/hds_seq.sv
rtl/core/heat_diffusion_stencil.sv
dv/diffusion_tracker_pkg.sv
dv/tb_top.sv
